// File: rtl/cgt_pkg.sv
// ---------------------------------------------------------------------------
// cgt_pkg
// Shared widths, codes and types of the CSR graph edge table.
// ---------------------------------------------------------------------------
`default_nettype none

package cgt_pkg;

  localparam int VID_W    = 8;
  localparam int KIND_W   = 3;
  localparam int IDX_W    = 11;
  localparam int STATUS_W = 2;
  localparam int RD_W     = 12;
  localparam int VCNT_W   = 9;
  localparam int ECNT_W   = 12;

  localparam int DEF_MAX_VERTICES = 256;
  localparam int DEF_MAX_EDGES    = 2048;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_ADD_VERTEX = kind_t'(0);
  localparam kind_t KIND_REM_VERTEX = kind_t'(1);
  localparam kind_t KIND_ADD_EDGE   = kind_t'(2);
  localparam kind_t KIND_REM_EDGE   = kind_t'(3);
  localparam kind_t KIND_RD_OFFSET  = kind_t'(4);
  localparam kind_t KIND_RD_TARGET  = kind_t'(5);

  localparam status_t STAT_OK        = status_t'(0);
  localparam status_t STAT_FULL      = status_t'(1);
  localparam status_t STAT_BAD_ID    = status_t'(2);
  localparam status_t STAT_NOT_FOUND = status_t'(3);

  // source in the upper half, so a plain compare orders by source, then target
  typedef struct packed {
    logic [VID_W-1:0] src;
    logic [VID_W-1:0] tgt;
  } entry_t;

  typedef struct packed {
    logic   pop;
    logic   push;
    entry_t data;
  } chain_ctl_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_BUSY,
    FSM_FIN
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADDV,
    OP_DELV,
    OP_INS,
    OP_DELE,
    OP_RDOFF,
    OP_RDEDGE
  } op_t;

endpackage

`default_nettype wire

// File: rtl/cgt_if.sv
// ---------------------------------------------------------------------------
// cgt_if
// Valid/ready channels for command beats and result beats.
// ---------------------------------------------------------------------------
`default_nettype none

interface cgt_in_if;
  logic                        valid;
  logic                        ready;
  logic [cgt_pkg::KIND_W-1:0]  kind;
  logic [cgt_pkg::VID_W-1:0]   vertex_a;
  logic [cgt_pkg::VID_W-1:0]   vertex_b;
  logic [cgt_pkg::IDX_W-1:0]   index;

  modport source (output valid, kind, vertex_a, vertex_b, index, input ready);
  modport sink   (input valid, kind, vertex_a, vertex_b, index, output ready);
endinterface

interface cgt_out_if;
  logic                          valid;
  logic                          ready;
  logic [cgt_pkg::STATUS_W-1:0]  status;
  logic [cgt_pkg::VID_W-1:0]     new_vertex;
  logic [cgt_pkg::RD_W-1:0]      read_value;
  logic [cgt_pkg::VCNT_W-1:0]    vertex_count;
  logic [cgt_pkg::ECNT_W-1:0]    edge_count;

  modport source (output valid, status, new_vertex, read_value, vertex_count, edge_count,
                  input ready);
  modport sink   (input valid, status, new_vertex, read_value, vertex_count, edge_count,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/cgt_cell.sv
// ---------------------------------------------------------------------------
// cgt_cell
// Edge chain slot: load on a write hit, else take the neighbor on a pop.
// ---------------------------------------------------------------------------
`default_nettype none

module cgt_cell #(
  parameter int IDX   = 0,
  parameter int DEPTH = cgt_pkg::DEF_MAX_EDGES,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            pop,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_idx,
  input  wire cgt_pkg::entry_t wr_data,
  input  wire cgt_pkg::entry_t nxt_in,
  output cgt_pkg::entry_t      q
);

  localparam logic [AW-1:0] MY_IDX = AW'(IDX);

  cgt_pkg::entry_t q_r;

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == MY_IDX)) begin
      q_r <= wr_data;
    end else if (pop) begin
      q_r <= nxt_in;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// File: rtl/cgt_chain.sv
// ---------------------------------------------------------------------------
// cgt_chain
// Row of edge cells used as a shift FIFO: pop at cell 0, push at the fill level.
// ---------------------------------------------------------------------------
`default_nettype none

module cgt_chain #(
  parameter int DEPTH  = cgt_pkg::DEF_MAX_EDGES,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cgt_pkg::chain_ctl_t ctl,
  output cgt_pkg::entry_t          head,
  output logic [CNT_W-1:0]         fill
);

  localparam int AW = $clog2(DEPTH);

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [AW-1:0]    wr_idx;
  cgt_pkg::entry_t  cell_q [DEPTH];

  // on a pop the tail moves down one, so the pushed beat lands one lower
  assign wr_idx = ctl.pop ? AW'(fill_r - CNT_W'(1)) : AW'(fill_r);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_last
      cgt_cell #(.IDX(i), .DEPTH(DEPTH)) u_cell (
        .clk     (clk),
        .pop     (ctl.pop),
        .wr_en   (ctl.push),
        .wr_idx  (wr_idx),
        .wr_data (ctl.data),
        .nxt_in  (cell_q[i]),
        .q       (cell_q[i])
      );
    end else begin : g_mid
      cgt_cell #(.IDX(i), .DEPTH(DEPTH)) u_cell (
        .clk     (clk),
        .pop     (ctl.pop),
        .wr_en   (ctl.push),
        .wr_idx  (wr_idx),
        .wr_data (ctl.data),
        .nxt_in  (cell_q[i+1]),
        .q       (cell_q[i])
      );
    end
  end

  always_comb begin
    fill_nxt = fill_r + CNT_W'(ctl.push) - CNT_W'(ctl.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign head = cell_q[0];
  assign fill = fill_r;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> (fill_r != '0))
    else $error("chain pop while empty");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.push && !ctl.pop) |-> (fill_r != CNT_W'(DEPTH)))
    else $error("chain push while full");

  a_pop_only_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.pop && !ctl.push) |=> (fill_r == $past(fill_r) - CNT_W'(1)))
    else $error("chain fill did not drop on a bare pop");

endmodule

`default_nettype wire

// File: rtl/cgt_ctrl.sv
// ---------------------------------------------------------------------------
// cgt_ctrl
// Command sequencer: checks a beat, at most one chain pass, forms the result.
// ---------------------------------------------------------------------------
`default_nettype none

module cgt_ctrl #(
  parameter int MAX_VERTICES = cgt_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = cgt_pkg::DEF_MAX_EDGES,
  localparam int CNT_W       = $clog2(MAX_EDGES + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  cgt_in_if.sink               in_if,
  cgt_out_if.source            out_if,
  output cgt_pkg::chain_ctl_t  ctl,
  input  wire cgt_pkg::entry_t head,
  input  wire logic [CNT_W-1:0] fill
);

  localparam int VID_W = cgt_pkg::VID_W;
  localparam int IDX_W = cgt_pkg::IDX_W;
  localparam int VT_W  = $clog2(MAX_VERTICES + 1);
  localparam int VC_W  = ((VT_W > VID_W) ? VT_W : VID_W) + 1;
  localparam int M1_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int IC_W  = ((M1_W > VT_W) ? M1_W : VT_W) + 1;

  cgt_pkg::state_t  state_r, state_nxt;
  cgt_pkg::op_t     op_r, op_nxt;
  logic [VID_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] left_r, left_nxt, cnt_r, cnt_nxt, acc_r, acc_nxt;
  logic [VID_W-1:0] tgt_r, tgt_nxt;
  cgt_pkg::status_t status_r, status_nxt;
  logic [VID_W-1:0] newv_r, newv_nxt;
  logic             pend1_r, pend1_nxt, pend2_r, pend2_nxt;
  cgt_pkg::entry_t  k1_r, k1_nxt, k2_r, k2_nxt;
  logic             drop_ab_r, drop_ab_nxt, drop_ba_r, drop_ba_nxt;
  logic [VT_W-1:0]  vtot_r, vtot_nxt;

  logic                         out_valid_r, out_valid_nxt;
  cgt_pkg::status_t             out_status_r, out_status_nxt;
  logic [VID_W-1:0]             out_newv_r, out_newv_nxt;
  logic [cgt_pkg::RD_W-1:0]     out_rd_r, out_rd_nxt;
  logic [cgt_pkg::VCNT_W-1:0]   out_vcnt_r, out_vcnt_nxt;
  logic [cgt_pkg::ECNT_W-1:0]   out_ecnt_r, out_ecnt_nxt;

  cgt_pkg::entry_t  key_ab, key_ba, front, ren;
  logic             has, pend_any, a_ok, b_ok;
  logic [VT_W-1:0]  vt_new;

  always_comb begin
    key_ab   = '{src: in_if.vertex_a, tgt: in_if.vertex_b};
    key_ba   = '{src: in_if.vertex_b, tgt: in_if.vertex_a};
    a_ok     = VC_W'(in_if.vertex_a) < VC_W'(vtot_r);
    b_ok     = VC_W'(in_if.vertex_b) < VC_W'(vtot_r);
    has      = (left_r != '0);
    pend_any = pend1_r || pend2_r;
    front    = pend1_r ? k1_r : k2_r;
    ren      = head;
    if (head.src > a_r) ren.src = head.src - VID_W'(1);
    if (head.tgt > a_r) ren.tgt = head.tgt - VID_W'(1);
    unique case (op_r)
      cgt_pkg::OP_ADDV: vt_new = vtot_r + VT_W'(1);
      cgt_pkg::OP_DELV: vt_new = vtot_r - VT_W'(1);
      default:          vt_new = vtot_r;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    idx_nxt     = idx_r;
    left_nxt    = left_r;
    cnt_nxt     = cnt_r;
    acc_nxt     = acc_r;
    tgt_nxt     = tgt_r;
    status_nxt  = status_r;
    newv_nxt    = newv_r;
    pend1_nxt   = pend1_r;
    pend2_nxt   = pend2_r;
    k1_nxt      = k1_r;
    k2_nxt      = k2_r;
    drop_ab_nxt = drop_ab_r;
    drop_ba_nxt = drop_ba_r;
    vtot_nxt    = vtot_r;

    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_newv_nxt   = out_newv_r;
    out_rd_nxt     = out_rd_r;
    out_vcnt_nxt   = out_vcnt_r;
    out_ecnt_nxt   = out_ecnt_r;

    ctl      = '0;
    ctl.data = head;

    unique case (state_r)
      cgt_pkg::FSM_IDLE: begin
        if (in_if.valid) begin
          a_nxt       = in_if.vertex_a;
          b_nxt       = in_if.vertex_b;
          idx_nxt     = in_if.index;
          left_nxt    = '0;
          cnt_nxt     = '0;
          acc_nxt     = '0;
          tgt_nxt     = '0;
          status_nxt  = cgt_pkg::STAT_OK;
          newv_nxt    = '0;
          pend1_nxt   = 1'b0;
          pend2_nxt   = 1'b0;
          drop_ab_nxt = 1'b1;
          drop_ba_nxt = 1'b1;
          k1_nxt      = (key_ab <= key_ba) ? key_ab : key_ba;
          k2_nxt      = (key_ab <= key_ba) ? key_ba : key_ab;
          op_nxt      = cgt_pkg::OP_NONE;
          state_nxt   = cgt_pkg::FSM_BUSY;
          unique case (in_if.kind)
            cgt_pkg::KIND_ADD_VERTEX: begin
              if (VC_W'(vtot_r) >= VC_W'(MAX_VERTICES)) begin
                status_nxt = cgt_pkg::STAT_FULL;
              end else begin
                op_nxt   = cgt_pkg::OP_ADDV;
                newv_nxt = VID_W'(vtot_r);
              end
            end
            cgt_pkg::KIND_REM_VERTEX: begin
              if (!a_ok) begin
                status_nxt = cgt_pkg::STAT_BAD_ID;
              end else begin
                op_nxt   = cgt_pkg::OP_DELV;
                left_nxt = fill;
              end
            end
            cgt_pkg::KIND_ADD_EDGE: begin
              if (!a_ok || !b_ok) begin
                status_nxt = cgt_pkg::STAT_BAD_ID;
              end else if (IC_W'(fill) + IC_W'(2) > IC_W'(MAX_EDGES)) begin
                status_nxt = cgt_pkg::STAT_FULL;
              end else begin
                op_nxt    = cgt_pkg::OP_INS;
                left_nxt  = fill;
                pend1_nxt = 1'b1;
                pend2_nxt = 1'b1;
              end
            end
            cgt_pkg::KIND_REM_EDGE: begin
              if (!a_ok || !b_ok) begin
                status_nxt = cgt_pkg::STAT_BAD_ID;
              end else begin
                op_nxt   = cgt_pkg::OP_DELE;
                left_nxt = fill;
              end
            end
            cgt_pkg::KIND_RD_OFFSET: begin
              if (IC_W'(in_if.index) > IC_W'(vtot_r)) begin
                status_nxt = cgt_pkg::STAT_BAD_ID;
              end else begin
                op_nxt   = cgt_pkg::OP_RDOFF;
                left_nxt = fill;
              end
            end
            cgt_pkg::KIND_RD_TARGET: begin
              if (IC_W'(in_if.index) >= IC_W'(fill)) begin
                status_nxt = cgt_pkg::STAT_BAD_ID;
              end else begin
                op_nxt   = cgt_pkg::OP_RDEDGE;
                left_nxt = fill;
              end
            end
            default: begin
              op_nxt = cgt_pkg::OP_NONE;
            end
          endcase
        end
      end

      cgt_pkg::FSM_BUSY: begin
        unique case (op_r)
          cgt_pkg::OP_INS: begin
            // place a new entry ahead of the first strictly larger one
            if (pend_any && (!has || (head > front))) begin
              ctl.push = 1'b1;
              ctl.data = front;
              if (pend1_r) pend1_nxt = 1'b0;
              else         pend2_nxt = 1'b0;
            end else if (has) begin
              ctl.pop  = 1'b1;
              ctl.push = 1'b1;
              left_nxt = left_r - CNT_W'(1);
            end
          end
          cgt_pkg::OP_DELV: begin
            if (has) begin
              ctl.pop  = 1'b1;
              left_nxt = left_r - CNT_W'(1);
              if ((head.src != a_r) && (head.tgt != a_r)) begin
                ctl.push = 1'b1;
                ctl.data = ren;
              end
            end
          end
          cgt_pkg::OP_DELE: begin
            if (has) begin
              ctl.pop  = 1'b1;
              left_nxt = left_r - CNT_W'(1);
              if (drop_ab_r && (head == cgt_pkg::entry_t'({a_r, b_r}))) begin
                drop_ab_nxt = 1'b0;
              end else if (drop_ba_r && (head == cgt_pkg::entry_t'({b_r, a_r}))) begin
                drop_ba_nxt = 1'b0;
              end else begin
                ctl.push = 1'b1;
              end
            end
          end
          cgt_pkg::OP_RDOFF: begin
            if (has) begin
              ctl.pop  = 1'b1;
              ctl.push = 1'b1;
              left_nxt = left_r - CNT_W'(1);
              if (IC_W'(head.src) < IC_W'(idx_r)) acc_nxt = acc_r + CNT_W'(1);
            end
          end
          cgt_pkg::OP_RDEDGE: begin
            if (has) begin
              ctl.pop  = 1'b1;
              ctl.push = 1'b1;
              left_nxt = left_r - CNT_W'(1);
              cnt_nxt  = cnt_r + CNT_W'(1);
              if (IC_W'(cnt_r) == IC_W'(idx_r)) tgt_nxt = head.tgt;
            end
          end
          default: begin
          end
        endcase
        if (!has && !((op_r == cgt_pkg::OP_INS) && pend_any)) begin
          state_nxt = cgt_pkg::FSM_FIN;
        end
      end

      cgt_pkg::FSM_FIN: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          if ((op_r == cgt_pkg::OP_DELE) && drop_ab_r && drop_ba_r) begin
            out_status_nxt = cgt_pkg::STAT_NOT_FOUND;
          end
          out_newv_nxt = newv_r;
          unique case (op_r)
            cgt_pkg::OP_RDOFF:  out_rd_nxt = cgt_pkg::RD_W'(acc_r);
            cgt_pkg::OP_RDEDGE: out_rd_nxt = cgt_pkg::RD_W'(tgt_r);
            default:            out_rd_nxt = '0;
          endcase
          out_vcnt_nxt = cgt_pkg::VCNT_W'(vt_new);
          out_ecnt_nxt = cgt_pkg::ECNT_W'(fill);
          vtot_nxt     = vt_new;
          state_nxt    = cgt_pkg::FSM_IDLE;
        end
      end

      default: begin
        state_nxt = cgt_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cgt_pkg::FSM_IDLE;
      op_r        <= cgt_pkg::OP_NONE;
      left_r      <= '0;
      pend1_r     <= 1'b0;
      pend2_r     <= 1'b0;
      vtot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      left_r      <= left_nxt;
      pend1_r     <= pend1_nxt;
      pend2_r     <= pend2_nxt;
      vtot_r      <= vtot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    acc_r        <= acc_nxt;
    tgt_r        <= tgt_nxt;
    status_r     <= status_nxt;
    newv_r       <= newv_nxt;
    k1_r         <= k1_nxt;
    k2_r         <= k2_nxt;
    drop_ab_r    <= drop_ab_nxt;
    drop_ba_r    <= drop_ba_nxt;
    out_status_r <= out_status_nxt;
    out_newv_r   <= out_newv_nxt;
    out_rd_r     <= out_rd_nxt;
    out_vcnt_r   <= out_vcnt_nxt;
    out_ecnt_r   <= out_ecnt_nxt;
  end

  assign in_if.ready         = (state_r == cgt_pkg::FSM_IDLE);
  assign out_if.valid        = out_valid_r;
  assign out_if.status       = out_status_r;
  assign out_if.new_vertex   = out_newv_r;
  assign out_if.read_value   = out_rd_r;
  assign out_if.vertex_count = out_vcnt_r;
  assign out_if.edge_count   = out_ecnt_r;

  a_chain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != cgt_pkg::FSM_BUSY) |-> (!ctl.pop && !ctl.push))
    else $error("chain moved outside a pass");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> (state_r == cgt_pkg::FSM_BUSY))
    else $error("accepted beat did not start a pass");

  a_fin_posts: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == cgt_pkg::FSM_FIN) && (!out_valid_r || out_if.ready))
      |=> (out_valid_r && (state_r == cgt_pkg::FSM_IDLE)))
    else $error("finished item did not post a result");

endmodule

`default_nettype wire

// File: rtl/csr_graph_edge_table.sv
// ---------------------------------------------------------------------------
// csr_graph_edge_table
// Undirected graph kept as a sorted list of directed edge entries (CSR).
// ---------------------------------------------------------------------------
// Usage:
//   in_if  : command beats (kind, vertex_a, vertex_b, index), valid/ready.
//   out_if : one result beat per command (status, new_vertex, read_value,
//            vertex_count, edge_count), valid/ready, held until taken.
//   The edge entries live in a row of MAX_EDGES cells that works as a shift
//   FIFO. Every chain edit or edge/offset read streams the stored entries once
//   out of cell 0 and back in at the tail, editing on the way; the list stays
//   sorted by source, then target, and offsets are counted on the fly.
//   Add vertex, unknown kinds and rejected commands make no pass over the
//   chain; add edge pushes its two new entries during the pass.
//   One command is in flight at a time; in_if.ready is high only when idle,
//   and a new command is taken while an earlier result still waits on out_if.
//   Reset clears vertex and entry counts and the control; entry cells hold
//   junk until written and are never read beyond the fill level.
//   A stalled out_if holds the result and the finished command waits in its
//   final state until the output register frees up.
// ---------------------------------------------------------------------------
`default_nettype none

module csr_graph_edge_table #(
  parameter int MAX_VERTICES = cgt_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = cgt_pkg::DEF_MAX_EDGES
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cgt_in_if.sink      in_if,
  cgt_out_if.source   out_if
);

  localparam int CNT_W = $clog2(MAX_EDGES + 1);

  // control to the chain: pop the head beat and/or push one at the tail
  cgt_pkg::chain_ctl_t ctl;
  cgt_pkg::entry_t     head;
  logic [CNT_W-1:0]    fill;

  cgt_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .ctl    (ctl),
    .head   (head),
    .fill   (fill)
  );

  // edge store: fill equals the entry count whenever no pass runs
  cgt_chain #(
    .DEPTH (MAX_EDGES)
  ) u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .head  (head),
    .fill  (fill)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CSR graph edge table: directed and random command
// beats against a behavioral edge list, results compared field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = cgt_pkg::DEF_MAX_VERTICES;
  localparam int NE = cgt_pkg::DEF_MAX_EDGES;
  localparam int WATCHDOG = 40000;

  typedef struct packed {
    cgt_pkg::kind_t kind;
    logic [7:0]     va;
    logic [7:0]     vb;
    logic [10:0]    idx;
  } cmd_t;

  typedef struct packed {
    cgt_pkg::status_t status;
    logic [7:0]       new_vertex;
    logic [11:0]      read_value;
    logic [8:0]       vertex_count;
    logic [11:0]      edge_count;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cgt_in_if  in_if ();
  cgt_out_if out_if ();

  csr_graph_edge_table dut (.clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if));

  // Shadow graph: sorted directed entries and offset table
  int unsigned g_src [NE];
  int unsigned g_tgt [NE];
  int unsigned g_off [NV+1];
  int unsigned g_nv, g_ne;

  cmd_t   cmd_q [$];
  reply_t reply_q [$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     stim_done = 0;

  function automatic void rebuild_offsets();
    int unsigned e;
    e = 0;
    for (int unsigned v = 0; v <= NV; v++) begin
      if (v > g_nv) begin
        g_off[v] = 0;
      end else begin
        while (e < g_ne && g_src[e] < v) e++;
        g_off[v] = e;
      end
    end
  endfunction

  function automatic void insert_entry(int unsigned a, int unsigned b);
    int unsigned pos;
    pos = g_off[a];
    while (pos < g_off[a+1] && g_tgt[pos] <= b) pos++;
    for (int i = int'(g_ne); i > int'(pos); i--) begin
      g_src[i] = g_src[i-1];
      g_tgt[i] = g_tgt[i-1];
    end
    g_src[pos] = a;
    g_tgt[pos] = b;
    g_ne++;
    for (int unsigned v = a + 1; v <= g_nv; v++) g_off[v]++;
  endfunction

  function automatic bit erase_entry(int unsigned a, int unsigned b);
    int unsigned pos;
    pos = g_off[a];
    while (pos < g_off[a+1] && g_tgt[pos] < b) pos++;
    if (pos >= g_off[a+1] || g_tgt[pos] != b) return 1'b0;
    for (int unsigned i = pos; i + 1 < g_ne; i++) begin
      g_src[i] = g_src[i+1];
      g_tgt[i] = g_tgt[i+1];
    end
    g_ne--;
    for (int unsigned v = a + 1; v <= g_nv; v++) g_off[v]--;
    return 1'b1;
  endfunction

  function automatic void drop_vertex(int unsigned id);
    int unsigned w, s, t;
    w = 0;
    for (int unsigned i = 0; i < g_ne; i++) begin
      s = g_src[i];
      t = g_tgt[i];
      if (s != id && t != id) begin
        if (s > id) s--;
        if (t > id) t--;
        g_src[w] = s;
        g_tgt[w] = t;
        w++;
      end
    end
    g_ne = w;
    g_nv--;
    rebuild_offsets();
  endfunction

  // Apply one command to the shadow graph and return the expected reply
  function automatic reply_t predict_reply(cmd_t c);
    reply_t r;
    bit r1, r2;
    r = '0;
    r.status = cgt_pkg::STAT_OK;
    case (c.kind)
      cgt_pkg::KIND_ADD_VERTEX: begin
        if (g_nv >= NV) begin
          r.status = cgt_pkg::STAT_FULL;
        end else begin
          r.new_vertex = g_nv[7:0];
          g_off[g_nv+1] = g_ne;
          g_nv++;
        end
      end
      cgt_pkg::KIND_REM_VERTEX: begin
        if (c.va >= g_nv) r.status = cgt_pkg::STAT_BAD_ID;
        else drop_vertex(c.va);
      end
      cgt_pkg::KIND_ADD_EDGE: begin
        if (c.va >= g_nv || c.vb >= g_nv) begin
          r.status = cgt_pkg::STAT_BAD_ID;
        end else if (g_ne + 2 > NE) begin
          r.status = cgt_pkg::STAT_FULL;
        end else begin
          insert_entry(c.va, c.vb);
          insert_entry(c.vb, c.va);
        end
      end
      cgt_pkg::KIND_REM_EDGE: begin
        if (c.va >= g_nv || c.vb >= g_nv) begin
          r.status = cgt_pkg::STAT_BAD_ID;
        end else begin
          r1 = erase_entry(c.va, c.vb);
          r2 = erase_entry(c.vb, c.va);
          if (!r1 && !r2) r.status = cgt_pkg::STAT_NOT_FOUND;
        end
      end
      cgt_pkg::KIND_RD_OFFSET: begin
        if (c.idx > g_nv || c.idx > NV) r.status = cgt_pkg::STAT_BAD_ID;
        else r.read_value = g_off[c.idx][11:0];
      end
      cgt_pkg::KIND_RD_TARGET: begin
        if (c.idx >= g_ne) r.status = cgt_pkg::STAT_BAD_ID;
        else r.read_value = g_tgt[c.idx][11:0];
      end
      default: ;
    endcase
    r.vertex_count = g_nv[8:0];
    r.edge_count   = g_ne[11:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic cmd_t make_cmd(cgt_pkg::kind_t k, int a, int b, int i);
    cmd_t c;
    c.kind = k;
    c.va = a[7:0];
    c.vb = b[7:0];
    c.idx = i[10:0];
    return c;
  endfunction

  // append one command beat to the stimulus queue
  function automatic void add_cmd(cmd_t c);
    cmd_q = {cmd_q, c};
  endfunction

  initial begin
    forever #1 clk = ~clk;
  end

  // Fill the command queue: directed corners first, then weighted random
  initial begin
    int k, nvs;
    add_cmd(make_cmd(cgt_pkg::KIND_RD_OFFSET, 0, 0, 0));
    add_cmd(make_cmd(cgt_pkg::KIND_RD_TARGET, 0, 0, 0));
    add_cmd(make_cmd(cgt_pkg::KIND_REM_VERTEX, 0, 0, 0));
    add_cmd(make_cmd(cgt_pkg::KIND_ADD_EDGE, 0, 0, 0));
    for (int i = 0; i < 4; i++) add_cmd(make_cmd(cgt_pkg::KIND_ADD_VERTEX, 0, 0, 0));
    add_cmd(make_cmd(cgt_pkg::KIND_ADD_EDGE, 1, 1, 0));     // self loop
    add_cmd(make_cmd(cgt_pkg::KIND_ADD_EDGE, 0, 2, 0));
    add_cmd(make_cmd(cgt_pkg::KIND_ADD_EDGE, 2, 0, 0));     // duplicate
    add_cmd(make_cmd(cgt_pkg::KIND_ADD_EDGE, 3, 255, 0));   // bad id
    add_cmd(make_cmd(cgt_pkg::KIND_RD_TARGET, 0, 0, 5));
    add_cmd(make_cmd(cgt_pkg::KIND_RD_TARGET, 0, 0, 2047));
    add_cmd(make_cmd(cgt_pkg::KIND_RD_OFFSET, 0, 0, 4));
    add_cmd(make_cmd(cgt_pkg::KIND_RD_OFFSET, 0, 0, 5));
    add_cmd(make_cmd(cgt_pkg::KIND_REM_EDGE, 1, 1, 0));
    add_cmd(make_cmd(cgt_pkg::KIND_REM_EDGE, 1, 3, 0));     // not found
    add_cmd(make_cmd(cgt_pkg::KIND_REM_EDGE, 255, 0, 0));
    add_cmd(make_cmd(cgt_pkg::KIND_REM_VERTEX, 0, 0, 0));
    add_cmd(make_cmd(cgt_pkg::kind_t'(6), 255, 255, 2047));
    add_cmd(make_cmd(cgt_pkg::kind_t'(7), 0, 0, 0));
    // Random part, tracking an approximate vertex count to keep ids valid
    nvs = 3;
    for (int n = 0; n < 268; n++) begin
      k = $urandom_range(0, 99);
      if (k < 12) begin
        add_cmd(make_cmd(cgt_pkg::KIND_ADD_VERTEX, 0, 0, 0));
        if (nvs < NV) nvs++;
      end else if (k < 18) begin
        add_cmd(make_cmd(cgt_pkg::KIND_REM_VERTEX,
          (k == 12) ? $urandom_range(0, 255) : $urandom_range(0, nvs > 0 ? nvs - 1 : 0), 0, 0));
        if (nvs > 0) nvs--;
      end else if (k < 55) begin
        add_cmd(make_cmd(cgt_pkg::KIND_ADD_EDGE, $urandom_range(0, nvs > 0 ? nvs - 1 : 0),
                         $urandom_range(0, nvs > 0 ? nvs - 1 : 0), $urandom));
      end else if (k < 70) begin
        add_cmd(make_cmd(cgt_pkg::KIND_REM_EDGE, $urandom_range(0, nvs > 0 ? nvs - 1 : 0),
                         $urandom_range(0, nvs > 0 ? nvs - 1 : 0), 0));
      end else if (k < 80) begin
        add_cmd(make_cmd(cgt_pkg::KIND_RD_OFFSET, $urandom, $urandom,
                         (k == 70) ? $urandom_range(0, 2047) : $urandom_range(0, nvs + 1)));
      end else if (k < 95) begin
        add_cmd(make_cmd(cgt_pkg::KIND_RD_TARGET, $urandom, $urandom,
                         (k == 80) ? $urandom_range(0, 2047) : $urandom_range(0, 300)));
      end else begin
        add_cmd(make_cmd(cgt_pkg::kind_t'($urandom_range(0, 7)), $urandom, $urandom,
                         $urandom));
      end
    end
    stim_done = 1;
  end

  // Driver: present queued beats with random gaps
  int send_gap = 0;
  initial begin
    in_if.valid = 1'b0;
    in_if.kind = '0;
    in_if.vertex_a = '0;
    in_if.vertex_b = '0;
    in_if.index = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_if.ready) begin
      // hold the beat until taken
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_if.valid <= 1'b0;
    end else if (cmd_q.size() > 0) begin
      cmd_t c;
      reply_t p;
      c = cmd_q.pop_front();
      p = predict_reply(c);
      reply_q = {reply_q, p};
      in_if.valid <= 1'b1;
      in_if.kind <= c.kind;
      in_if.vertex_a <= c.va;
      in_if.vertex_b <= c.vb;
      in_if.index <= c.idx;
      send_gap <= pick_gap();
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // Monitor: random backpressure, compare each result beat
  int stall = 0;
  initial out_if.ready = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (reply_q.size() == 0) begin
          $error("unexpected result beat");
          errors++;
        end else begin
          reply_t e;
          e = reply_q.pop_front();
          if (out_if.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_if.status); errors++;
          end
          if (out_if.new_vertex !== e.new_vertex) begin
            $error("new_vertex exp %0d got %0d", e.new_vertex, out_if.new_vertex); errors++;
          end
          if (out_if.read_value !== e.read_value) begin
            $error("read_value exp %0d got %0d", e.read_value, out_if.read_value); errors++;
          end
          if (out_if.vertex_count !== e.vertex_count) begin
            $error("vertex_count exp %0d got %0d", e.vertex_count, out_if.vertex_count);
            errors++;
          end
          if (out_if.edge_count !== e.edge_count) begin
            $error("edge_count exp %0d got %0d", e.edge_count, out_if.edge_count); errors++;
          end
        end
      end
      // advance the stall counter; drop ready while it runs
      if (stall > 0) begin
        stall <= stall - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        stall <= pick_gap();
      end
    end
  end

  // Watchdog: count cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    @(posedge clk);
    while (cmd_q.size() > 0 || reply_q.size() > 0 || in_if.valid) begin
      if (idle_cycles >= WATCHDOG) begin
        $display("RESULT: ERROR");
        $finish;
      end
      @(posedge clk);
    end
    repeat (NE + 20) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/cgt_pkg.sv
rtl/cgt_if.sv
rtl/cgt_cell.sv
rtl/cgt_chain.sv
rtl/cgt_ctrl.sv
rtl/csr_graph_edge_table.sv
tb/sv/tb_top.sv
